FILE: rtl/core/assert_macros.svh
// Assertion macros used by the framer's byte sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dwpf_pkg.sv
// Types and constants shared by the display window pixel framer
package dwpf_pkg;

    localparam logic [1:0] FUNC_WINDOW = 2'd0;
    localparam logic [1:0] FUNC_PIXEL  = 2'd1;
    localparam logic [1:0] FUNC_RAW    = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [1:0] CFG_GRAY     = 2'd0;
    localparam logic [1:0] CFG_COL_OP   = 2'd1;
    localparam logic [1:0] CFG_PAGE_OP  = 2'd2;
    localparam logic [1:0] CFG_MEMWR_OP = 2'd3;

    localparam logic [7:0] RST_COL_OP   = 8'd42;
    localparam logic [7:0] RST_PAGE_OP  = 8'd43;
    localparam logic [7:0] RST_MEMWR_OP = 8'd44;

    localparam logic [15:0] GRAY_WR = 16'd77;
    localparam logic [15:0] GRAY_WG = 16'd150;
    localparam logic [15:0] GRAY_WB = 16'd29;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;
    localparam int CNT_W   = 4;

    typedef struct packed {
        logic       gray_enable;
        logic [7:0] col_op;
        logic [7:0] page_op;
        logic [7:0] memwr_op;
    } t_cfg;

    // window: xs, xe, ys, ye from high to low
    // pixel:  r in [23:16], g in [15:8], b in [7:0]
    // raw:    dc level in [8], byte in [7:0]
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] data;
    } t_rec;

endpackage

FILE: rtl/core/display_window_pixel_framer.sv
// Top level of the display window pixel framer: config registers and the three parts
// Output: one byte per cycle while requests wait and the receiver is ready; a pixel
// is 3 bytes, a window 11, a raw byte 1, paced by the byte sequencer; a 4-entry
// queue decouples the two ends.
// Reset (synchronous, active low) empties the pipeline and queue, sets gray mode off
// and the column, page and memory-write command bytes to 42, 43 and 44.
module display_window_pixel_framer
    import dwpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_x_start,
    input  logic [15:0] i_x_end,
    input  logic [15:0] i_y_start,
    input  logic [15:0] i_y_end,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_raw_byte,
    input  logic        i_raw_is_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_spi_byte,
    output logic        o_dc_flag,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg r_cfg;
    logic s_push_valid;
    logic s_push_ready;
    t_rec s_push_rec;
    logic s_pop_valid;
    logic s_pop_ready;
    t_rec s_pop_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gray_enable <= 1'b0;
            r_cfg.col_op      <= RST_COL_OP;
            r_cfg.page_op     <= RST_PAGE_OP;
            r_cfg.memwr_op    <= RST_MEMWR_OP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRAY:     r_cfg.gray_enable <= i_cfg_data[0];
                CFG_COL_OP:   r_cfg.col_op      <= i_cfg_data;
                CFG_PAGE_OP:  r_cfg.page_op     <= i_cfg_data;
                CFG_MEMWR_OP: r_cfg.memwr_op    <= i_cfg_data;
                default:      r_cfg             <= r_cfg;
            endcase
        end
    end

    dwpf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_x_start     (i_x_start),
        .i_x_end       (i_x_end),
        .i_y_start     (i_y_start),
        .i_y_end       (i_y_end),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_raw_byte    (i_raw_byte),
        .i_raw_is_data (i_raw_is_data),
        .o_push_valid  (s_push_valid),
        .i_push_ready  (s_push_ready),
        .o_push_rec    (s_push_rec)
    );

    dwpf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_push_valid),
        .o_push_ready (s_push_ready),
        .i_push_rec   (s_push_rec),
        .o_pop_valid  (s_pop_valid),
        .i_pop_ready  (s_pop_ready),
        .o_pop_rec    (s_pop_rec)
    );

    dwpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (s_pop_valid),
        .o_pop_ready (s_pop_ready),
        .i_pop_rec   (s_pop_rec),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_spi_byte  (o_spi_byte),
        .o_dc_flag   (o_dc_flag),
        .o_last      (o_last)
    );

endmodule

FILE: rtl/core/dwpf_front.sv
// Front end: accept requests, drop unused selectors, convert pixels to gray when gray mode is on
module dwpf_front
    import dwpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_x_start,
    input  logic [15:0] i_x_end,
    input  logic [15:0] i_y_start,
    input  logic [15:0] i_y_end,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_raw_byte,
    input  logic        i_raw_is_data,
    output logic        o_push_valid,
    input  logic        i_push_ready,
    output t_rec        o_push_rec
);

    logic        r_valid;
    t_rec        r_rec;
    t_rec        n_rec;
    logic [15:0] s_sum;
    logic [7:0]  s_gray;
    logic [7:0]  s_r;
    logic [7:0]  s_g;
    logic [7:0]  s_b;

    assign s_sum  = ({8'd0, i_red} * GRAY_WR) + ({8'd0, i_green} * GRAY_WG)
                  + ({8'd0, i_blue} * GRAY_WB);
    assign s_gray = s_sum[15:8];
    assign s_r    = i_cfg.gray_enable ? s_gray : i_red;
    assign s_g    = i_cfg.gray_enable ? s_gray : i_green;
    assign s_b    = i_cfg.gray_enable ? s_gray : i_blue;

    always_comb begin
        n_rec.kind = i_func;
        case (i_func)
            FUNC_WINDOW: n_rec.data = {i_x_start, i_x_end, i_y_start, i_y_end};
            FUNC_PIXEL:  n_rec.data = {40'd0, s_r, s_g, s_b};
            FUNC_RAW:    n_rec.data = {55'd0, i_raw_is_data, i_raw_byte};
            default:     n_rec.data = 64'd0;
        endcase
    end

    assign o_in_ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid && (i_func != FUNC_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_rec <= n_rec;
        end
    end

endmodule

FILE: rtl/core/dwpf_queue.sv
// Short request queue between front end and byte sequencer
module dwpf_queue
    import dwpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_rec i_push_rec,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_rec o_pop_rec
);

    t_rec            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic            s_push;
    logic            s_pop;

    assign o_push_ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_rec    = r_mem[r_rd_ptr];
    assign s_push       = i_push_valid && o_push_ready;
    assign s_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (s_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (s_push && !s_pop) begin
                r_count <= r_count + 1'b1;
            end else if (s_pop && !s_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

endmodule

FILE: rtl/core/dwpf_back.sv
// Byte sequencer: expand each request into tagged bytes with an output register
`include "assert_macros.svh"

module dwpf_back
    import dwpf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    input  t_rec       i_pop_rec,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_spi_byte,
    output logic       o_dc_flag,
    output logic       o_last
);

    localparam logic [CNT_W-1:0] SLOT_COL_OP  = 4'd0;
    localparam logic [CNT_W-1:0] SLOT_XS_HI   = 4'd1;
    localparam logic [CNT_W-1:0] SLOT_XS_LO   = 4'd2;
    localparam logic [CNT_W-1:0] SLOT_XE_HI   = 4'd3;
    localparam logic [CNT_W-1:0] SLOT_XE_LO   = 4'd4;
    localparam logic [CNT_W-1:0] SLOT_PAGE_OP = 4'd5;
    localparam logic [CNT_W-1:0] SLOT_YS_HI   = 4'd6;
    localparam logic [CNT_W-1:0] SLOT_YS_LO   = 4'd7;
    localparam logic [CNT_W-1:0] SLOT_YE_HI   = 4'd8;
    localparam logic [CNT_W-1:0] SLOT_YE_LO   = 4'd9;
    localparam logic [CNT_W-1:0] SLOT_MEMWR   = 4'd10;
    localparam logic [CNT_W-1:0] SLOT_RED     = 4'd0;
    localparam logic [CNT_W-1:0] SLOT_GREEN   = 4'd1;
    localparam logic [CNT_W-1:0] SLOT_BLUE    = 4'd2;

    logic             r_busy;
    t_rec             r_rec;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic [7:0]       r_byte;
    logic             r_dc;
    logic             r_last;
    logic             s_adv;
    logic [7:0]       s_byte;
    logic             s_dc;
    logic             s_end;

    always_comb begin
        s_byte = 8'd0;
        s_dc   = 1'b1;
        s_end  = 1'b0;
        case (r_rec.kind)
            FUNC_WINDOW: begin
                case (r_cnt)
                    SLOT_COL_OP: begin
                        s_byte = i_cfg.col_op;
                        s_dc   = 1'b0;
                    end
                    SLOT_XS_HI:   s_byte = r_rec.data[63:56];
                    SLOT_XS_LO:   s_byte = r_rec.data[55:48];
                    SLOT_XE_HI:   s_byte = r_rec.data[47:40];
                    SLOT_XE_LO:   s_byte = r_rec.data[39:32];
                    SLOT_PAGE_OP: begin
                        s_byte = i_cfg.page_op;
                        s_dc   = 1'b0;
                    end
                    SLOT_YS_HI:   s_byte = r_rec.data[31:24];
                    SLOT_YS_LO:   s_byte = r_rec.data[23:16];
                    SLOT_YE_HI:   s_byte = r_rec.data[15:8];
                    SLOT_YE_LO:   s_byte = r_rec.data[7:0];
                    default: begin
                        s_byte = i_cfg.memwr_op;
                        s_dc   = 1'b0;
                        s_end  = 1'b1;
                    end
                endcase
            end
            FUNC_PIXEL: begin
                case (r_cnt)
                    SLOT_RED:   s_byte = r_rec.data[23:16];
                    SLOT_GREEN: s_byte = r_rec.data[15:8];
                    default: begin
                        s_byte = r_rec.data[7:0];
                        s_end  = 1'b1;
                    end
                endcase
            end
            default: begin
                s_byte = r_rec.data[7:0];
                s_dc   = r_rec.data[8];
                s_end  = 1'b1;
            end
        endcase
    end

    assign s_adv       = r_busy && (!r_out_valid || i_out_ready);
    assign o_pop_ready = !r_busy || (s_adv && s_end);
    assign o_out_valid = r_out_valid;
    assign o_spi_byte  = r_byte;
    assign o_dc_flag   = r_dc;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop_ready) begin
                r_busy <= i_pop_valid;
                r_cnt  <= '0;
            end else if (s_adv) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (s_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop_valid && o_pop_ready) begin
            r_rec <= i_pop_rec;
        end
        if (s_adv) begin
            r_byte <= s_byte;
            r_dc   <= s_dc;
            r_last <= s_end;
        end
    end

    `ASSERT_IMPLY(a_pixel_slot, i_clk, i_rst_n,
        r_busy && (r_rec.kind == FUNC_PIXEL), r_cnt <= SLOT_BLUE,
        "pixel slot out of range")
    `ASSERT_IMPLY(a_window_slot, i_clk, i_rst_n,
        r_busy && (r_rec.kind == FUNC_WINDOW), r_cnt <= SLOT_MEMWR,
        "window slot out of range")
    `ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n,
        i_pop_valid && o_pop_ready, r_busy && (r_cnt == '0),
        "popped request not loaded")
    `ASSERT_NEXT(a_end_marked, i_clk, i_rst_n,
        s_adv && s_end, o_out_valid && o_last,
        "final byte not marked")

endmodule

FILE: tb/display_window_pixel_framer_tb.sv
// Testbench for the display window pixel framer: byte scoreboard class, drivers and checks

typedef struct {
    logic [1:0]  func;
    logic [15:0] x_start;
    logic [15:0] x_end;
    logic [15:0] y_start;
    logic [15:0] y_end;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  raw_byte;
    logic        raw_is_data;
} t_display_req;

typedef struct {
    logic [7:0] spi_byte;
    logic       dc_flag;
    logic       last;
} t_link_byte;

class link_byte_tracker;
    t_link_byte pending_bytes[$];
    int         errors;
    logic       gray_on;
    logic [7:0] col_op;
    logic [7:0] page_op;
    logic [7:0] memwr_op;

    function new();
        errors   = 0;
        gray_on  = 1'b0;
        col_op   = dwpf_pkg::RST_COL_OP;
        page_op  = dwpf_pkg::RST_PAGE_OP;
        memwr_op = dwpf_pkg::RST_MEMWR_OP;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
        case (idx)
            dwpf_pkg::CFG_GRAY:     gray_on  = val[0];
            dwpf_pkg::CFG_COL_OP:   col_op   = val;
            dwpf_pkg::CFG_PAGE_OP:  page_op  = val;
            dwpf_pkg::CFG_MEMWR_OP: memwr_op = val;
            default: ;
        endcase
    endfunction

    function void push_byte(logic [7:0] b, logic dc, logic last);
        t_link_byte e;
        e.spi_byte = b;
        e.dc_flag  = dc;
        e.last     = last;
        pending_bytes.push_back(e);
    endfunction

    function logic [7:0] to_luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned sum;
        sum = (77 * r + 150 * g + 29 * b) >> 8;
        return (sum > 255) ? 8'hff : sum[7:0];
    endfunction

    function void note_request(t_display_req req);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = req.red;
        g = req.green;
        b = req.blue;
        case (req.func)
            dwpf_pkg::FUNC_WINDOW: begin
                push_byte(col_op, 1'b0, 1'b0);
                push_byte(req.x_start[15:8], 1'b1, 1'b0);
                push_byte(req.x_start[7:0], 1'b1, 1'b0);
                push_byte(req.x_end[15:8], 1'b1, 1'b0);
                push_byte(req.x_end[7:0], 1'b1, 1'b0);
                push_byte(page_op, 1'b0, 1'b0);
                push_byte(req.y_start[15:8], 1'b1, 1'b0);
                push_byte(req.y_start[7:0], 1'b1, 1'b0);
                push_byte(req.y_end[15:8], 1'b1, 1'b0);
                push_byte(req.y_end[7:0], 1'b1, 1'b0);
                push_byte(memwr_op, 1'b0, 1'b1);
            end
            dwpf_pkg::FUNC_PIXEL: begin
                if (gray_on) begin
                    r = to_luma(req.red, req.green, req.blue);
                    g = r;
                    b = r;
                end
                push_byte(r, 1'b1, 1'b0);
                push_byte(g, 1'b1, 1'b0);
                push_byte(b, 1'b1, 1'b1);
            end
            dwpf_pkg::FUNC_RAW: begin
                push_byte(req.raw_byte, req.raw_is_data, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function void check_byte(logic [7:0] b, logic dc, logic last);
        t_link_byte e;
        if (pending_bytes.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected transfer: byte %02h dc %0d last %0d", b, dc, last);
            return;
        end
        e = pending_bytes.pop_front();
        if (b !== e.spi_byte || dc !== e.dc_flag || last !== e.last) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch: expected byte %02h dc %0d last %0d, ",
                          "got byte %02h dc %0d last %0d"},
                         e.spi_byte, e.dc_flag, e.last, b, dc, last);
        end
    endfunction

    function int pending();
        return pending_bytes.size();
    endfunction
endclass

module display_window_pixel_framer_tb;
    import dwpf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [15:0] i_x_start;
    logic [15:0] i_x_end;
    logic [15:0] i_y_start;
    logic [15:0] i_y_end;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic [7:0]  i_raw_byte;
    logic        i_raw_is_data;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_spi_byte;
    logic        o_dc_flag;
    logic        o_last;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    link_byte_tracker tracker = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles         = 0;

    display_window_pixel_framer dut (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_byte(o_spi_byte, o_dc_flag, o_last);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_display_req make_req(logic [1:0] func, logic [15:0] xs,
                                              logic [15:0] xe, logic [15:0] ys,
                                              logic [15:0] ye, logic [7:0] r,
                                              logic [7:0] g, logic [7:0] b,
                                              logic [7:0] raw, logic dc);
        t_display_req req;
        req.func        = func;
        req.x_start     = xs;
        req.x_end       = xe;
        req.y_start     = ys;
        req.y_end       = ye;
        req.red         = r;
        req.green       = g;
        req.blue        = b;
        req.raw_byte    = raw;
        req.raw_is_data = dc;
        return req;
    endfunction

    function automatic logic [15:0] rand16();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 16'hffff : 16'h0000;
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] rand8();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 8'hff : 8'h00;
        return 8'($urandom);
    endfunction

    function automatic t_display_req random_req();
        int unsigned  pick;
        logic [1:0]   func;
        pick = $urandom_range(99);
        if (pick < 35)
            func = FUNC_WINDOW;
        else if (pick < 75)
            func = FUNC_PIXEL;
        else if (pick < 95)
            func = FUNC_RAW;
        else
            func = FUNC_NONE;
        return make_req(func, rand16(), rand16(), rand16(), rand16(),
                        rand8(), rand8(), rand8(), rand8(), 1'($urandom_range(1)));
    endfunction

    task automatic send_req(t_display_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= req.func;
        i_x_start     <= req.x_start;
        i_x_end       <= req.x_end;
        i_y_start     <= req.y_start;
        i_y_end       <= req.y_end;
        i_red         <= req.red;
        i_green       <= req.green;
        i_blue        <= req.blue;
        i_raw_byte    <= req.raw_byte;
        i_raw_is_data <= req.raw_is_data;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        tracker.note_request(req);
    endtask

    // hold off until every expected byte is out, then wait on so any stray extra byte is still checked
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic apply_config(logic [7:0] gray, logic [7:0] col, logic [7:0] page,
                                logic [7:0] memwr);
        logic [7:0] vals [4];
        vals = '{gray, col, page, memwr};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 2'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            tracker.set_reg(2'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(int n, int s_pct, int r_pct);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        repeat (n) send_req(random_req());
        drain();
    endtask

    initial begin
        t_display_req plain_reqs[$];
        t_display_req gray_reqs[$];

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_func        <= FUNC_NONE;
        i_x_start     <= '0;
        i_x_end       <= '0;
        i_y_start     <= '0;
        i_y_end       <= '0;
        i_red         <= '0;
        i_green       <= '0;
        i_blue        <= '0;
        i_raw_byte    <= '0;
        i_raw_is_data <= 1'b0;
        i_out_ready   <= 1'b1;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_GRAY;
        i_cfg_data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        plain_reqs = '{
            make_req(FUNC_WINDOW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 0),
            make_req(FUNC_WINDOW, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 0, 0),
            make_req(FUNC_WINDOW, 16'h1234, 16'habcd, 16'h00ff, 16'hff00,
                     8'hff, 8'hff, 8'hff, 8'hff, 1),
            make_req(FUNC_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 0),
            make_req(FUNC_PIXEL, 0, 0, 0, 0, 8'hff, 8'hff, 8'hff, 0, 0),
            make_req(FUNC_PIXEL, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                     8'h80, 8'h7f, 8'h01, 8'hff, 1),
            make_req(FUNC_RAW, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0),
            make_req(FUNC_RAW, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                     8'hff, 8'hff, 8'hff, 8'hff, 1),
            make_req(FUNC_RAW, 0, 0, 0, 0, 0, 0, 0, 8'ha5, 0),
            make_req(FUNC_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                     8'hff, 8'hff, 8'hff, 8'hff, 1),
            make_req(FUNC_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            make_req(FUNC_PIXEL, 0, 0, 0, 0, 8'h12, 8'h34, 8'h56, 0, 0)
        };
        gray_reqs = '{
            make_req(FUNC_PIXEL, 0, 0, 0, 0, 8'hff, 8'hff, 8'hff, 0, 0),
            make_req(FUNC_PIXEL, 0, 0, 0, 0, 8'hff, 8'h00, 8'h00, 0, 0),
            make_req(FUNC_PIXEL, 0, 0, 0, 0, 8'h00, 8'hff, 8'h00, 0, 0),
            make_req(FUNC_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'hff, 0, 0),
            make_req(FUNC_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 0),
            make_req(FUNC_PIXEL, 0, 0, 0, 0, 8'h64, 8'hc8, 8'h32, 0, 0),
            make_req(FUNC_WINDOW, 16'h0001, 16'hfffe, 16'h8000, 16'h7fff, 0, 0, 0, 0, 0),
            make_req(FUNC_RAW, 0, 0, 0, 0, 0, 0, 0, 8'h3c, 1),
            make_req(FUNC_NONE, 0, 0, 0, 0, 8'hff, 8'hff, 8'hff, 0, 0)
        };

        foreach (plain_reqs[i])
            send_req(plain_reqs[i]);
        drain();

        // gray on through an odd value with upper bits set
        apply_config(8'ha3, 8'h00, 8'hff, 8'h80);
        foreach (gray_reqs[i])
            send_req(gray_reqs[i]);
        drain();

        run_random(70, 0, 0);
        apply_config(8'hfe, 8'hff, 8'h00, 8'($urandom));
        run_random(65, 74, 0);
        apply_config(8'h01, 8'($urandom), 8'($urandom), 8'hff);
        run_random(65, 0, 74);
        apply_config(8'h00, 8'($urandom), 8'($urandom), 8'h00);
        run_random(70, 23, 23);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
